// ===== sv/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg
// Types, codes and reply tables shared by the telnet receive deframer.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Telnet protocol bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_EOR  = 8'd239;

  // Option codes
  localparam logic [7:0] OPT_BIN = 8'd0;
  localparam logic [7:0] OPT_TT  = 8'd24;
  localparam logic [7:0] OPT_EOR = 8'd25;
  localparam logic [7:0] OPT_ENV = 8'd39;

  // Burst lengths
  localparam int unsigned SINGLE_LEN  = 1;
  localparam int unsigned TRIPLET_LEN = 3;
  localparam int unsigned TT_LEN      = 6;
  localparam int unsigned ENV_LEN     = 25;
  localparam int unsigned IDX_W       = $clog2(ENV_LEN);

  // Command queue
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_IAC    = 3'd1,
    ST_VERB   = 3'd2,
    ST_SB     = 3'd3,
    ST_SB_IAC = 3'd4
  } parse_state_e;

  typedef enum logic [1:0] {
    VERB_DO   = 2'd0,
    VERB_DONT = 2'd1,
    VERB_WILL = 2'd2,
    VERB_WONT = 2'd3
  } verb_e;

  typedef enum logic [2:0] {
    K_DATA  = 3'd0,
    K_EOR   = 3'd1,
    K_REPLY = 3'd2,
    K_SB    = 3'd3,
    K_SBEND = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_SINGLE  = 2'd0,
    CMD_TRIPLET = 2'd1,
    CMD_TT      = 2'd2,
    CMD_ENV     = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    kind_e      kind;
    logic [7:0] verb;
    logic [7:0] value;
  } cmd_t;

  // Environment SEND request sent on WILL NEW-ENVIRON in host mode
  function automatic logic [7:0] env_byte(logic [IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'd255;
      5'd1:    b = 8'd250;
      5'd2:    b = 8'd39;
      5'd3:    b = 8'd1;
      5'd4:    b = 8'd3;
      5'd5:    b = 8'd73;
      5'd6:    b = 8'd66;
      5'd7:    b = 8'd77;
      5'd8:    b = 8'd82;
      5'd9:    b = 8'd83;
      5'd10:   b = 8'd69;
      5'd11:   b = 8'd69;
      5'd12:   b = 8'd68;
      5'd13:   b = 8'd0;
      5'd14:   b = 8'd1;
      5'd15:   b = 8'd2;
      5'd16:   b = 8'd3;
      5'd17:   b = 8'd4;
      5'd18:   b = 8'd5;
      5'd19:   b = 8'd6;
      5'd20:   b = 8'd7;
      5'd21:   b = 8'd0;
      5'd22:   b = 8'd3;
      5'd23:   b = 8'd255;
      5'd24:   b = 8'd240;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // Terminal type SEND request: IAC SB 24 1 IAC SE
  function automatic logic [7:0] tt_byte(logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = B_IAC;
      3'd1:    b = B_SB;
      3'd2:    b = OPT_TT;
      3'd3:    b = 8'd1;
      3'd4:    b = B_IAC;
      3'd5:    b = B_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/trd_front.sv =====
// ----------------------------------------------------------------------------
// trd_front
// Parses received bytes and turns each into at most one queued command.
// ----------------------------------------------------------------------------
module trd_front
  import trd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       host_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       push_o,
  output cmd_t       push_cmd_o,
  input  logic       push_ready_i
);

  parse_state_e state_q, state_d;
  verb_e        verb_q, verb_d;
  logic         rec_open_q, rec_open_d;
  logic         accept;
  logic         has_cmd;
  logic         known_opt;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign known_opt  = (in_byte_i == OPT_TT) || (in_byte_i == OPT_EOR) ||
                      (in_byte_i == OPT_BIN) || (in_byte_i == OPT_ENV);

  // Next state
  always_comb begin
    state_d    = state_q;
    verb_d     = verb_q;
    rec_open_d = rec_open_q;
    if (accept) begin
      case (state_q)
        ST_IAC: begin
          state_d = ST_DATA;
          if (in_byte_i == B_IAC) begin
            rec_open_d = 1'b1;
          end else if (in_byte_i == B_DO) begin
            verb_d  = VERB_DO;
            state_d = ST_VERB;
          end else if (in_byte_i == B_DONT) begin
            verb_d  = VERB_DONT;
            state_d = ST_VERB;
          end else if (in_byte_i == B_WILL) begin
            verb_d  = VERB_WILL;
            state_d = ST_VERB;
          end else if (in_byte_i == B_WONT) begin
            verb_d  = VERB_WONT;
            state_d = ST_VERB;
          end else if (in_byte_i == B_SB) begin
            state_d = ST_SB;
          end else if (in_byte_i == B_EOR) begin
            rec_open_d = 1'b0;
          end
        end
        ST_VERB: begin
          state_d = ST_DATA;
        end
        ST_SB: begin
          if (in_byte_i == B_IAC) begin
            state_d = ST_SB_IAC;
          end
        end
        ST_SB_IAC: begin
          state_d = (in_byte_i == B_SE) ? ST_DATA : ST_SB;
        end
        default: begin
          if (in_byte_i == B_IAC) begin
            state_d = ST_IAC;
          end else begin
            state_d    = ST_DATA;
            rec_open_d = 1'b1;
          end
        end
      endcase
    end
  end

  // Command build
  always_comb begin
    has_cmd          = 1'b0;
    push_cmd_o.op    = CMD_SINGLE;
    push_cmd_o.kind  = K_DATA;
    push_cmd_o.verb  = 8'd0;
    push_cmd_o.value = in_byte_i;
    case (state_q)
      ST_IAC: begin
        if (in_byte_i == B_IAC) begin
          has_cmd = 1'b1;
        end else if (in_byte_i == B_EOR && rec_open_q) begin
          has_cmd          = 1'b1;
          push_cmd_o.kind  = K_EOR;
          push_cmd_o.value = 8'd0;
        end
      end
      ST_VERB: begin
        push_cmd_o.kind = K_REPLY;
        if (host_mode_i) begin
          if (verb_q == VERB_WILL) begin
            if (in_byte_i == OPT_ENV) begin
              has_cmd       = 1'b1;
              push_cmd_o.op = CMD_ENV;
            end else if (in_byte_i == OPT_TT) begin
              has_cmd       = 1'b1;
              push_cmd_o.op = CMD_TT;
            end else if (in_byte_i == OPT_EOR || in_byte_i == OPT_BIN) begin
              has_cmd         = 1'b1;
              push_cmd_o.op   = CMD_TRIPLET;
              push_cmd_o.verb = B_WILL;
            end
          end
        end else if (verb_q == VERB_DO) begin
          has_cmd         = 1'b1;
          push_cmd_o.op   = CMD_TRIPLET;
          push_cmd_o.verb = known_opt ? B_WILL : B_WONT;
        end else if (verb_q == VERB_WILL) begin
          has_cmd         = 1'b1;
          push_cmd_o.op   = CMD_TRIPLET;
          push_cmd_o.verb = known_opt ? B_DO : B_DONT;
        end
      end
      ST_SB: begin
        if (in_byte_i != B_IAC) begin
          has_cmd         = 1'b1;
          push_cmd_o.kind = K_SB;
        end
      end
      ST_SB_IAC: begin
        if (in_byte_i == B_IAC) begin
          has_cmd         = 1'b1;
          push_cmd_o.kind = K_SB;
        end else if (in_byte_i == B_SE) begin
          has_cmd          = 1'b1;
          push_cmd_o.kind  = K_SBEND;
          push_cmd_o.value = 8'd0;
        end
      end
      default: begin
        has_cmd = (in_byte_i != B_IAC);
      end
    endcase
  end

  assign push_o = accept && has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_DATA;
      verb_q     <= VERB_DO;
      rec_open_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      verb_q     <= verb_d;
      rec_open_q <= rec_open_d;
    end
  end

endmodule

// ===== sv/trd_fifo.sv =====
// ----------------------------------------------------------------------------
// trd_fifo
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module trd_fifo
  import trd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue over depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i)
    else $error("pop from empty command queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow command queue");
`endif

endmodule

// ===== sv/trd_back.sv =====
// ----------------------------------------------------------------------------
// trd_back
// Expands queued commands into result items in an output register, one per
// cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module trd_back
  import trd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_value_o,
  output logic       out_last_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] item_len;
  logic [7:0]       item_value;
  logic             item_last;
  logic             load;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_kind_q;
  logic [7:0]       out_value_q;
  logic             out_last_q;

  always_comb begin
    case (cmd_i.op)
      CMD_SINGLE: begin
        item_len   = IDX_W'(SINGLE_LEN);
        item_value = cmd_i.value;
      end
      CMD_TRIPLET: begin
        item_len = IDX_W'(TRIPLET_LEN);
        case (idx_q)
          IDX_W'(0): item_value = B_IAC;
          IDX_W'(1): item_value = cmd_i.verb;
          default:   item_value = cmd_i.value;
        endcase
      end
      CMD_TT: begin
        item_len   = IDX_W'(TT_LEN);
        item_value = tt_byte(idx_q[2:0]);
      end
      default: begin
        item_len   = IDX_W'(ENV_LEN);
        item_value = env_byte(idx_q);
      end
    endcase
  end

  assign item_last = (idx_q == item_len - 1'b1);
  assign load      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = load && item_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = item_last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= cmd_i.kind;
      out_value_q <= item_value;
      out_last_q  <= item_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (load && item_last))
    else $error("command popped before its last item");
  a_burst_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> cmd_valid_i)
    else $error("command left mid-burst");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q < item_len))
    else $error("burst index past command length");
  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (out_valid_o && out_last_o))
    else $error("popped command did not end with a last item");
`endif

endmodule

// ===== sv/telnet_receive_deframer.sv =====
// ----------------------------------------------------------------------------
// telnet_receive_deframer
// Telnet receive deframer: strips IAC escapes, marks records, passes
// subnegotiation payload and answers option negotiation.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata           tuser      tlast
//  s_axis    in         rx_byte[7:0]    -          -
//  m_axis    out        value[7:0]      kind[2:0]  last
//  cfg       in         host_mode (1 bit, written on cfg_we_i)
//
//  Cycles: one received byte is taken per cycle while the command queue has
//  room; each result item leaves the output register one per cycle unless
//  stalled. A reply burst of N items (3, 6 or 25) holds the result sequencer
//  to its last item; the two-entry command queue fills and intake stalls.
//  Output stalls back up through the output register into the queue.
//  Reset (async, active low) clears parser state, queue and host_mode; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
module telnet_receive_deframer
  import trd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // host_mode
  // received bytes
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] rx_byte
  // result items
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] value
  output logic [2:0] m_axis_tuser_o,  // [2:0] kind
  output logic       m_axis_tlast_o   // last item caused by one received byte
);

  logic host_mode_q;
  logic push;
  cmd_t push_cmd;
  logic push_ready;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // Hold the negotiation policy; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      host_mode_q <= cfg_wdata_i;
    end
  end

  // Front: classify each byte and queue at most one command per transfer.
  trd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .host_mode_i  (host_mode_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  // Queue: decouple parsing from reply bursts.
  trd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // Back: advance through each command's items into the output register.
  trd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_value_o (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/deframer_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_sb_pkg
// Scoreboard for the telnet receive deframer: tracks the parser state and
// host_mode, predicts the results of each received byte, and checks every
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
package deframer_sb_pkg;
  import trd_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } deframer_result_t;

  class deframer_scoreboard;
    bit               host_mode;
    parse_state_e     pstate;
    verb_e            held_verb;
    bit               record_open;
    deframer_result_t expected_q[$];
    deframer_result_t burst_q[$];
    int unsigned      fail_count;
    logic [7:0]       env_req [25];

    function new();
      host_mode   = 1'b0;
      pstate      = ST_DATA;
      held_verb   = VERB_DO;
      record_open = 1'b0;
      fail_count  = 0;
      // environment SEND request: IAC SB NEW-ENVIRON SEND USERVAR <name> ...
      env_req = '{8'd255, 8'd250, 8'd39, 8'd1, 8'd3,
                  8'd73, 8'd66, 8'd77, 8'd82, 8'd83, 8'd69, 8'd69, 8'd68,
                  8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
                  8'd0, 8'd3, 8'd255, 8'd240};
    endfunction

    function void set_host_mode(bit v);
      host_mode = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add(kind_e k, logic [7:0] v);
      burst_q.push_back('{kind: k, value: v, last: 1'b0});
    endfunction

    function void add_reply_triplet(logic [7:0] verb, logic [7:0] opt);
      add(K_REPLY, B_IAC);
      add(K_REPLY, verb);
      add(K_REPLY, opt);
    endfunction

    function bit known_option(logic [7:0] opt);
      return opt == OPT_BIN || opt == OPT_TT || opt == OPT_EOR || opt == OPT_ENV;
    endfunction

    // Negotiation answer for the option byte that follows IAC <verb>
    function void answer_option(logic [7:0] opt);
      if (host_mode) begin
        if (held_verb == VERB_WILL) begin
          if (opt == OPT_ENV) begin
            foreach (env_req[i]) add(K_REPLY, env_req[i]);
          end else if (opt == OPT_TT) begin
            add(K_REPLY, B_IAC);
            add(K_REPLY, B_SB);
            add(K_REPLY, OPT_TT);
            add(K_REPLY, 8'd1);
            add(K_REPLY, B_IAC);
            add(K_REPLY, B_SE);
          end else if (opt == OPT_EOR || opt == OPT_BIN) begin
            add_reply_triplet(B_WILL, opt);
          end
        end
      end else begin
        if (held_verb == VERB_DO) begin
          add_reply_triplet(known_option(opt) ? B_WILL : B_WONT, opt);
        end else if (held_verb == VERB_WILL) begin
          add_reply_triplet(known_option(opt) ? B_DO : B_DONT, opt);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b);
      burst_q.delete();
      case (pstate)
        ST_IAC: begin
          pstate = ST_DATA;
          case (b)
            B_IAC: begin
              record_open = 1'b1;
              add(K_DATA, B_IAC);
            end
            B_DO: begin
              held_verb = VERB_DO;
              pstate    = ST_VERB;
            end
            B_DONT: begin
              held_verb = VERB_DONT;
              pstate    = ST_VERB;
            end
            B_WILL: begin
              held_verb = VERB_WILL;
              pstate    = ST_VERB;
            end
            B_WONT: begin
              held_verb = VERB_WONT;
              pstate    = ST_VERB;
            end
            B_SB: pstate = ST_SB;
            B_EOR: begin
              if (record_open) begin
                record_open = 1'b0;
                add(K_EOR, 8'd0);
              end
            end
            default: ;
          endcase
        end
        ST_VERB: begin
          answer_option(b);
          pstate = ST_DATA;
        end
        ST_SB: begin
          if (b == B_IAC) pstate = ST_SB_IAC;
          else add(K_SB, b);
        end
        ST_SB_IAC: begin
          if (b == B_IAC) begin
            add(K_SB, B_IAC);
            pstate = ST_SB;
          end else if (b == B_SE) begin
            add(K_SBEND, 8'd0);
            pstate = ST_DATA;
          end else begin
            pstate = ST_SB;
          end
        end
        default: begin
          if (b == B_IAC) begin
            pstate = ST_IAC;
          end else begin
            pstate      = ST_DATA;
            record_open = 1'b1;
            add(K_DATA, b);
          end
        end
      endcase
      if (burst_q.size() > 0) burst_q[burst_q.size()-1].last = 1'b1;
      foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] value, logic last);
      deframer_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0d value %0d last %0d",
               kind, value, last);
        fail_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (kind !== exp_r.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", exp_r.kind, kind);
        fail_count++;
      end
      if (value !== exp_r.value) begin
        $error("value mismatch: expected %0d, actual %0d", exp_r.value, value);
        fail_count++;
      end
      if (last !== exp_r.last) begin
        $error("last mismatch: expected %0d, actual %0d", exp_r.last, last);
        fail_count++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received telnet bytes into the deframer under random idling on
// both streams, switches host_mode between phases, and checks every result
// transfer against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import trd_pkg::*;
  import deframer_sb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASE_BYTES   = 45;
  localparam int unsigned RAND_PHASES   = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = 8'd0;
  logic       m_ready = 1'b0;
  wire        s_ready;
  wire        m_valid;
  wire  [7:0] m_data;
  wire  [2:0] m_user;
  wire        m_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent = 0;

  deframer_scoreboard sb;

  telnet_receive_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: drop tready at random per the current idle rate
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Note each byte transfer first, then check the result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) sb.note_byte(s_data);
      if (m_valid && m_ready) sb.check_result(m_user, m_data, m_last);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold the byte until it transfers; insert random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Data byte as it travels on the wire: 255 is doubled
  task automatic send_escaped(input logic [7:0] b);
    if (b == B_IAC) send_byte(B_IAC);
    send_byte(b);
  endtask

  // Drop valid, wait until every predicted result has arrived, then let
  // the pipeline settle so that no byte without results is still in flight
  task automatic quiesce();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_host_mode(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_host_mode(v);
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 5))
      0:       return OPT_BIN;
      1:       return OPT_TT;
      2:       return OPT_EOR;
      3:       return OPT_ENV;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random sequence: mostly well-formed telnet, some noise
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(1, 6);
      repeat (n) send_escaped(8'($urandom_range(0, 255)));
    end else if (pick < 45) begin
      send_byte(B_IAC);
      send_byte(B_EOR);
    end else if (pick < 70) begin
      send_byte(B_IAC);
      case ($urandom_range(0, 3))
        0:       send_byte(B_DO);
        1:       send_byte(B_DONT);
        2:       send_byte(B_WILL);
        default: send_byte(B_WONT);
      endcase
      send_byte(pick_option());
    end else if (pick < 85) begin
      send_byte(B_IAC);
      send_byte(B_SB);
      send_byte(pick_option());
      n = $urandom_range(0, 5);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
          // stray escape inside the subnegotiation
          send_byte(B_IAC);
          send_byte(b);
        end else begin
          send_escaped(b);
        end
      end
      // leave the subnegotiation open now and then
      if ($urandom_range(0, 9) != 0) begin
        send_byte(B_IAC);
        send_byte(B_SE);
      end
    end else begin
      n = $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 0) send_byte(B_IAC);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, client policy
    send_idle_pct = 26;
    recv_idle_pct = 73;
    write_host_mode(1'b0);
    send_byte(B_IAC); send_byte(B_EOR);                    // EOR with no record open
    send_byte(8'd0);
    send_byte(B_IAC); send_byte(B_IAC);                    // escaped 255 data byte
    send_byte(B_IAC); send_byte(B_EOR);                    // closes the record
    send_byte(B_IAC); send_byte(B_DO);   send_byte(OPT_TT);
    send_byte(B_IAC); send_byte(B_WILL); send_byte(8'd200);
    send_byte(B_IAC); send_byte(B_WONT); send_byte(OPT_EOR);
    send_byte(B_IAC); send_byte(B_SE);                     // SE outside a subnegotiation
    send_byte(B_IAC); send_byte(B_SB);   send_byte(OPT_TT);
    send_byte(B_IAC); send_byte(B_IAC);                    // escaped 255 inside SB
    send_byte(B_IAC); send_byte(8'd1);                     // unknown escape inside SB
    send_byte(B_IAC); send_byte(B_SE);
    quiesce();

    // Directed, host policy
    send_idle_pct = 73;
    recv_idle_pct = 26;
    write_host_mode(1'b1);
    send_byte(B_IAC); send_byte(B_WILL); send_byte(OPT_ENV);
    send_byte(B_IAC); send_byte(B_WILL); send_byte(OPT_TT);
    send_byte(B_IAC); send_byte(B_WILL); send_byte(OPT_BIN);
    send_byte(B_IAC); send_byte(B_DO);   send_byte(OPT_BIN);
    quiesce();

    // Random phases: every idle pattern with both host_mode settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 3)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_host_mode(p % 2 == 1);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_sequence();
      quiesce();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
